// ===== hdl/bpa_pkg.sv =====
// shared constants, types and helpers of the block pool allocator
package bpa_pkg;

   localparam int MAX_BLOCKS  = 256;
   localparam int SLOT_W      = $clog2(MAX_BLOCKS);
   localparam int LINK_W      = SLOT_W + 1;
   localparam int BYTES_W     = 16;
   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 9;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int DIVIDEND_W  = SLOT_W + BYTES_W;
   localparam int PROD_W      = LINK_W + BYTES_W;
   localparam int STEP_W      = $clog2(LINK_W + 1);

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ALLOCATED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_POOL_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREED         = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd2;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } bpa_alu_op_type;

   typedef struct packed {
      logic           start;
      bpa_alu_op_type op;
   } bpa_alu_ctl_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } bpa_alu_stat_type;

   // number of blocks actually in the pool
   function automatic logic [LINK_W-1:0] used_blocks(input logic [COUNT_W-1:0] count,
                                                     input logic [BYTES_W-1:0] bytes);
      logic [LINK_W-1:0] n;
      if (bytes == '0) begin
         n = '0;
      end else if (32'(count) > MAX_BLOCKS) begin
         n = LINK_W'(MAX_BLOCKS);
      end else begin
         n = LINK_W'(count);
      end
      return n;
   endfunction

endpackage

// ===== hdl/block_pool_allocator.sv =====
// top level of the fixed-size block pool allocator
//
// fixed-size block pool allocator with a lifo free stack linked through a
// 256-entry next-index memory. each request item carries a command in
// req_tuser (0 allocate, 1 free) and a byte address in req_tdata; each one
// gives exactly one response item with a status in rsp_tuser and the
// allocated block address in rsp_tdata (zero unless allocated). one item
// is worked on at a time and req_tready is low until its result has been
// handed to the response register. an allocate on a non-empty pool is one
// multiply of the block index by the block size, nine steps of the shared
// shift-add unit, plus table read and result load. a free is nine steps to
// multiply block count by block size for the range check and, if in range,
// eight steps of restoring division of the offset by the block size on the
// same adder. a csr write (always ready) to any of the three registers
// re-forms the free stack at once: every pool block free, block 0 on top if
// the pool is non-empty. index 3 is accepted and ignored. double frees are
// not detected. csr writes are only allowed while no item is in flight.
module block_pool_allocator (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bpa_pkg::ADDR_W-1:0]    req_tdata,   // [31:0] address
   input  logic [0:0]                    req_tuser,   // [0] command
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bpa_pkg::ADDR_W-1:0]    rsp_tdata,   // [31:0] block_address
   output logic [bpa_pkg::STATUS_W-1:0]  rsp_tuser,   // [2:0] status
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpa_pkg::ADDR_W-1:0]    csr_data
);
   import bpa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_SPAN,
      S_DIV,
      S_OUT
   } seq_state_type;

   // sequencer and control state
   seq_state_type        state_ff, state_in;
   logic [LINK_W-1:0]    top_ff, top_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [ADDR_W-1:0]    base_ff, base_in;

   // payload
   logic [ADDR_W-1:0]    offset_ff, offset_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;

   // shared unit and link memory hookup
   bpa_alu_ctl_type      alu_ctl;
   bpa_alu_stat_type     alu_stat;
   logic [DIVIDEND_W-1:0] alu_a;
   logic [PROD_W-1:0]    alu_product;
   logic [SLOT_W-1:0]    alu_quotient;

   logic                 link_clear;
   logic                 link_rd_en;
   logic [LINK_W-1:0]    link_rd_data;
   logic                 link_wr_en;

   logic                 req_fire;
   logic                 csr_fire;
   logic                 csr_hit;
   logic [COUNT_W-1:0]   new_count;
   logic [BYTES_W-1:0]   new_bytes;
   logic [LINK_W-1:0]    used_now;
   logic [LINK_W-1:0]    used_new;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign csr_hit    = csr_fire && ((csr_index == CSR_BLOCK_COUNT) ||
                                    (csr_index == CSR_BLOCK_BYTES) ||
                                    (csr_index == CSR_BASE_ADDRESS));

   // pool size as it will be after a register write this cycle
   assign new_count = (csr_fire && csr_index == CSR_BLOCK_COUNT) ?
                      csr_data[COUNT_W-1:0] : count_ff;
   assign new_bytes = (csr_fire && csr_index == CSR_BLOCK_BYTES) ?
                      csr_data[BYTES_W-1:0] : bytes_ff;
   assign used_now  = used_blocks(count_ff, bytes_ff);
   assign used_new  = used_blocks(new_count, new_bytes);

   assign link_clear = csr_hit;

   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff;
      count_in      = new_count;
      bytes_in      = new_bytes;
      base_in       = base_ff;
      offset_in     = offset_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      alu_ctl.start = 1'b0;
      alu_ctl.op    = ALU_MUL;
      alu_a         = DIVIDEND_W'(top_ff);
      link_rd_en    = 1'b0;
      link_wr_en    = 1'b0;

      if (csr_fire && csr_index == CSR_BASE_ADDRESS) begin
         base_in = csr_data;
      end

      // response register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               offset_in = req_tdata - base_ff;
               if (req_tuser[0] == CMD_ALLOC) begin
                  if (top_ff == NULL_LINK) begin
                     res_status_in = ST_POOL_EMPTY;
                     res_addr_in   = '0;
                     state_in      = S_OUT;
                  end else begin
                     // fetch the next link while multiplying index by size
                     link_rd_en    = 1'b1;
                     alu_ctl.start = 1'b1;
                     alu_ctl.op    = ALU_MUL;
                     alu_a         = DIVIDEND_W'(top_ff);
                     state_in      = S_ALLOC;
                  end
               end else begin
                  // span of the pool for the range check
                  alu_ctl.start = 1'b1;
                  alu_ctl.op    = ALU_MUL;
                  alu_a         = DIVIDEND_W'(used_now);
                  state_in      = S_SPAN;
               end
            end
         end
         S_ALLOC: begin
            if (alu_stat.done) begin
               top_in        = link_rd_data;
               res_status_in = ST_ALLOCATED;
               res_addr_in   = base_ff + ADDR_W'(alu_product);
               state_in      = S_OUT;
            end
         end
         S_SPAN: begin
            if (alu_stat.done) begin
               if (offset_ff >= ADDR_W'(alu_product)) begin
                  res_status_in = ST_OUT_OF_RANGE;
                  res_addr_in   = '0;
                  state_in      = S_OUT;
               end else begin
                  // offset below the span fits the dividend width
                  alu_ctl.start = 1'b1;
                  alu_ctl.op    = ALU_DIV;
                  alu_a         = offset_ff[DIVIDEND_W-1:0];
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (alu_stat.done) begin
               res_addr_in = '0;
               if (alu_stat.rem_zero) begin
                  link_wr_en    = 1'b1;
                  top_in        = LINK_W'(alu_quotient);
                  res_status_in = ST_FREED;
               end else begin
                  res_status_in = ST_MISALIGNED;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // any register write re-forms the free stack
      if (csr_hit) begin
         top_in = (used_new != '0) ? '0 : NULL_LINK;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff     <= offset_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_W'(256);
         bytes_ff     <= BYTES_W'(64);
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         base_ff      <= base_in;
      end
   end

   bpa_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .ctl       (alu_ctl),
      .operand_a (alu_a),
      .operand_b (bytes_ff),
      .stat      (alu_stat),
      .product   (alu_product),
      .quotient  (alu_quotient)
   );

   bpa_link_table u_links (
      .clock      (clock),
      .reset      (reset),
      .clear      (link_clear),
      .used_count (used_now),
      .rd_en      (link_rd_en),
      .rd_addr    (top_ff[SLOT_W-1:0]),
      .rd_data    (link_rd_data),
      .wr_en      (link_wr_en),
      .wr_addr    (alu_quotient),
      .wr_data    (top_ff)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_addr_ff;

`ifndef SYNTH
   // the stack top is always a block index or the null link
   a_top_in_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= NULL_LINK)
      else $error("stack top beyond null link");

   // only allocations carry an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_ALLOCATED) |-> rsp_addr_ff == '0)
      else $error("non-allocate response with nonzero address");

   // an accepted item blocks the request side on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted twice in a row");

   // a shared unit result only arrives while the sequencer waits for one
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      alu_stat.done |-> (state_ff == S_ALLOC) || (state_ff == S_SPAN) ||
                        (state_ff == S_DIV))
      else $error("unit result with no step waiting");

   // a table write only happens on an aligned in-range free
   a_write_freed: assert property (@(posedge clock) disable iff (reset)
      link_wr_en |=> (res_status_ff == ST_FREED) && (state_ff == S_OUT))
      else $error("link write outside a free");
`endif

endmodule

// ===== hdl/bpa_link_table.sv =====
// next-index link memory with per-entry valid bits and computed reset links
module bpa_link_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic [bpa_pkg::LINK_W-1:0] used_count,
   input  logic                       rd_en,
   input  logic [bpa_pkg::SLOT_W-1:0] rd_addr,
   output logic [bpa_pkg::LINK_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [bpa_pkg::SLOT_W-1:0] wr_addr,
   input  logic [bpa_pkg::LINK_W-1:0] wr_data
);
   import bpa_pkg::*;

   logic [LINK_W-1:0]     mem [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] valid_ff;
   logic [LINK_W-1:0]     mem_q_ff;
   logic                  valid_q_ff;
   logic [LINK_W-1:0]     dflt_q_ff;
   logic [LINK_W-1:0]     succ;
   logic [LINK_W-1:0]     dflt_in;

   // an entry unwritten since the last rebuild links to successor or null
   assign succ    = LINK_W'(rd_addr) + LINK_W'(1);
   assign dflt_in = (succ < used_count) ? succ : NULL_LINK;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff   <= mem[rd_addr];
         valid_q_ff <= valid_ff[rd_addr];
         dflt_q_ff  <= dflt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = valid_q_ff ? mem_q_ff : dflt_q_ff;

endmodule

// ===== hdl/bpa_muldiv.sv =====
// shared shift-add multiplier and restoring divider on one adder
module bpa_muldiv (
   input  logic                           clock,
   input  logic                           reset,
   input  bpa_pkg::bpa_alu_ctl_type       ctl,
   input  logic [bpa_pkg::DIVIDEND_W-1:0] operand_a,
   input  logic [bpa_pkg::BYTES_W-1:0]    operand_b,
   output bpa_pkg::bpa_alu_stat_type      stat,
   output logic [bpa_pkg::PROD_W-1:0]     product,
   output logic [bpa_pkg::SLOT_W-1:0]     quotient
);
   import bpa_pkg::*;

   typedef enum logic {
      A_IDLE,
      A_RUN
   } alu_state_type;

   alu_state_type        state_ff, state_in;
   bpa_alu_op_type       op_ff, op_in;
   logic [STEP_W-1:0]    count_ff, count_in;
   logic                 done_ff, done_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [LINK_W-1:0]    mplier_ff, mplier_in;
   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dv_ff, dv_in;
   logic [SLOT_W-1:0]    q_ff, q_in;
   logic [BYTES_W-1:0]   b_ff, b_in;

   // the one adder
   logic [PROD_W-1:0]    add_x, add_y;
   logic                 add_sub;
   logic [PROD_W:0]      add_sum;
   logic                 carry;

   always_comb begin
      if (op_ff == ALU_DIV) begin
         add_x   = PROD_W'(rem_ff);
         add_y   = PROD_W'(dv_ff);
         add_sub = 1'b1;
      end else begin
         add_x   = acc_ff << 1;
         add_y   = mplier_ff[LINK_W-1] ? PROD_W'(b_ff) : '0;
         add_sub = 1'b0;
      end
      add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (PROD_W+1)'(add_sub);
      carry   = add_sum[PROD_W];
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      count_in  = count_ff;
      done_in   = 1'b0;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      dv_in     = dv_ff;
      q_in      = q_ff;
      b_in      = b_ff;
      case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               state_in  = A_RUN;
               op_in     = ctl.op;
               b_in      = operand_b;
               acc_in    = '0;
               mplier_in = operand_a[LINK_W-1:0];
               rem_in    = operand_a;
               dv_in     = DIVIDEND_W'(operand_b) << (SLOT_W - 1);
               q_in      = '0;
               count_in  = (ctl.op == ALU_DIV) ? STEP_W'(SLOT_W) : STEP_W'(LINK_W);
            end
         end
         A_RUN: begin
            if (op_ff == ALU_DIV) begin
               // carry out means the remainder covers the shifted divisor
               if (carry) begin
                  rem_in = add_sum[DIVIDEND_W-1:0];
               end
               q_in  = {q_ff[SLOT_W-2:0], carry};
               dv_in = dv_ff >> 1;
            end else begin
               acc_in    = add_sum[PROD_W-1:0];
               mplier_in = mplier_ff << 1;
            end
            count_in = count_ff - STEP_W'(1);
            if (count_ff == STEP_W'(1)) begin
               state_in = A_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      count_ff  <= count_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      dv_ff     <= dv_in;
      q_ff      <= q_in;
      b_ff      <= b_in;
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);
   assign product       = acc_ff;
   assign quotient      = q_ff;

endmodule
